// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file of the AT front end.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, disabled while reset is asserted (active low).
`define ATF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Concurrent check that also runs during reset.
`define ATF_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/atf_pkg.sv -----
// Package of the AT escape and command line front end: codes, constants,
// controller/datapath command and status types. No dependencies.
`default_nettype none

package atf_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_CHAR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EOL_CHAR     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BS_CHAR      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GUARD_TICKS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_ENABLE  = 3'd4;

    // Configuration reset values
    localparam logic [7:0] RST_ESCAPE_CHAR = 8'd43;
    localparam logic [7:0] RST_EOL_CHAR    = 8'd13;
    localparam logic [7:0] RST_BS_CHAR     = 8'd8;
    localparam logic [7:0] RST_GUARD_TICKS = 8'd50;
    localparam logic       RST_ECHO_ENABLE = 1'b1;

    // Result kinds
    localparam logic [2:0] KIND_LINE_BYTE = 3'd0;
    localparam logic [2:0] KIND_ECHO      = 3'd1;
    localparam logic [2:0] KIND_CMD_CHAR  = 3'd2;
    localparam logic [2:0] KIND_LINE_END  = 3'd3;
    localparam logic [2:0] KIND_REPEAT    = 3'd4;
    localparam logic [2:0] KIND_ENTERED   = 3'd5;

    // Characters
    localparam logic [7:0] CH_A        = 8'h41;
    localparam logic [7:0] CH_T        = 8'h54;
    localparam logic [7:0] CH_SLASH    = 8'h2F;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_BS_ECHO  = 8'h08;
    localparam logic [7:0] CH_LOWER_A  = 8'h61;
    localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
    localparam logic [7:0] CASE_OFFSET = 8'd32;

    // Escape characters in a complete escape sequence
    localparam logic [1:0] ESC_RUN = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_ESC,
        S_BYTE,
        S_ENTERED,
        S_ECHO,
        S_ECHO_T,
        S_ECHO_BS,
        S_ECHO_SP,
        S_REPEAT,
        S_LINE_RD,
        S_LINE,
        S_LEN
    } t_state;

    typedef enum logic [1:0] {
        PH_WAIT_A,
        PH_WAIT_T,
        PH_COLLECT
    } t_phase;

    // What follows a command-mode byte's echo, or its decision when echo is off
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_REPEAT,
        ACT_ECHO_T,
        ACT_ECHO_BS,
        ACT_LINE
    } t_act;

    typedef enum logic [3:0] {
        SEL_ESC_LINE,
        SEL_RAW_LINE,
        SEL_ENTERED,
        SEL_ECHO_RAW,
        SEL_ECHO_T,
        SEL_ECHO_BS,
        SEL_ECHO_SP,
        SEL_REPEAT,
        SEL_STORE,
        SEL_LEN
    } t_emit_sel;

    typedef enum logic [1:0] {
        LOP_NONE,
        LOP_CLEAR,
        LOP_PUSH,
        LOP_POP
    } t_line_op;

    typedef struct packed {
        logic      load;
        logic      emit;
        t_emit_sel emit_sel;
        logic      emit_last;
        t_line_op  line_op;
        logic      rd_start;
        logic      rd_next;
    } t_dp_cmd;

    typedef struct packed {
        logic kind;
        logic is_esc;
        logic gap_gt_guard;
        logic gap_lt_guard;
        logic is_a;
        logic is_t;
        logic is_slash;
        logic is_bs;
        logic is_eol;
        logic echo_en;
        logic line_empty;
        logic line_full;
        logic line_done;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

// ----- rtl/atf_if.sv -----
// Handshake interfaces of the AT front end: item, result and config write.
// Depends on atf_pkg.
`default_nettype none

interface atf_item_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  host_byte;
    logic [15:0] gap_ticks;
    modport source (output valid, kind, host_byte, gap_ticks, input ready);
    modport sink   (input valid, kind, host_byte, gap_ticks, output ready);
endinterface

interface atf_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] out_kind;
    logic [7:0] out_value;
    logic       last_of_run;
    modport source (output valid, out_kind, out_value, last_of_run, input ready);
    modport sink   (input valid, out_kind, out_value, last_of_run, output ready);
endinterface

interface atf_cfg_if;
    import atf_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [7:0]           data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/atf_datapath.sv -----
// Datapath of the AT front end: config registers, item register, line store,
// read port and output register. Depends on atf_pkg.
`default_nettype none

module atf_datapath #(
    parameter int LINE_DEPTH = 40
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire atf_pkg::t_dp_cmd             i_cmd,
    output atf_pkg::t_dp_sts                  o_sts,
    input  wire logic                         i_kind,
    input  wire logic [7:0]                   i_host_byte,
    input  wire logic [15:0]                  i_gap_ticks,
    input  wire logic                         i_cfg_valid,
    input  wire logic [atf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [7:0]                   i_cfg_data,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [2:0]                        o_out_kind,
    output logic [7:0]                        o_out_value,
    output logic                              o_last_of_run
);
    import atf_pkg::*;

    localparam int ADDR_W = $clog2(LINE_DEPTH);
    localparam int LEN_W  = $clog2(LINE_DEPTH + 1);

    logic [7:0]        r_escape_char;
    logic [7:0]        r_eol_char;
    logic [7:0]        r_bs_char;
    logic [7:0]        r_guard_ticks;
    logic              r_echo_enable;

    logic              r_kind;
    logic [7:0]        r_byte;
    logic [15:0]       r_gap;

    logic [7:0]        r_mem [LINE_DEPTH];
    logic [LEN_W-1:0]  r_line_len;
    logic [LEN_W-1:0]  r_rd_idx;
    logic [7:0]        r_rd_data;
    logic [ADDR_W-1:0] rd_addr;

    logic              r_out_valid;
    logic [2:0]        r_out_kind;
    logic [7:0]        r_out_value;
    logic              r_out_last;

    logic [7:0]        upper;
    logic              out_free;
    logic [2:0]        emit_kind;
    logic [7:0]        emit_value;

    // Config write port, always ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape_char <= RST_ESCAPE_CHAR;
            r_eol_char    <= RST_EOL_CHAR;
            r_bs_char     <= RST_BS_CHAR;
            r_guard_ticks <= RST_GUARD_TICKS;
            r_echo_enable <= RST_ECHO_ENABLE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ESCAPE_CHAR: r_escape_char <= i_cfg_data;
                CFG_EOL_CHAR:    r_eol_char    <= i_cfg_data;
                CFG_BS_CHAR:     r_bs_char     <= i_cfg_data;
                CFG_GUARD_TICKS: r_guard_ticks <= i_cfg_data;
                CFG_ECHO_ENABLE: r_echo_enable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_byte <= i_host_byte;
            r_gap  <= i_gap_ticks;
        end
    end

    always_comb begin
        upper = r_byte;
        if (r_byte >= CH_LOWER_A && r_byte <= CH_LOWER_Z) begin
            upper = r_byte - CASE_OFFSET;
        end
    end

    // Line length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_len <= '0;
        end else begin
            unique case (i_cmd.line_op)
                LOP_CLEAR: r_line_len <= '0;
                LOP_PUSH:  r_line_len <= r_line_len + 1'b1;
                LOP_POP:   r_line_len <= r_line_len - 1'b1;
                default: ;
            endcase
        end
    end

    // Line store: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.line_op == LOP_PUSH) begin
            r_mem[r_line_len[ADDR_W-1:0]] <= upper;
        end
    end

    assign rd_addr = i_cmd.rd_start ? '0 : r_rd_idx[ADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_start || i_cmd.rd_next) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx <= '0;
        end else if (i_cmd.rd_start) begin
            r_rd_idx <= LEN_W'(1);
        end else if (i_cmd.rd_next) begin
            r_rd_idx <= r_rd_idx + 1'b1;
        end
    end

    always_comb begin
        unique case (i_cmd.emit_sel)
            SEL_ESC_LINE: begin emit_kind = KIND_LINE_BYTE; emit_value = r_escape_char; end
            SEL_RAW_LINE: begin emit_kind = KIND_LINE_BYTE; emit_value = r_byte;        end
            SEL_ENTERED:  begin emit_kind = KIND_ENTERED;   emit_value = r_escape_char; end
            SEL_ECHO_RAW: begin emit_kind = KIND_ECHO;      emit_value = r_byte;        end
            SEL_ECHO_T:   begin emit_kind = KIND_ECHO;      emit_value = CH_T;          end
            SEL_ECHO_BS:  begin emit_kind = KIND_ECHO;      emit_value = CH_BS_ECHO;    end
            SEL_ECHO_SP:  begin emit_kind = KIND_ECHO;      emit_value = CH_SPACE;      end
            SEL_REPEAT:   begin emit_kind = KIND_REPEAT;    emit_value = '0;            end
            SEL_STORE:    begin emit_kind = KIND_CMD_CHAR;  emit_value = r_rd_data;     end
            SEL_LEN:      begin emit_kind = KIND_LINE_END;  emit_value = 8'(r_line_len); end
            default:      begin emit_kind = KIND_LINE_BYTE; emit_value = r_byte;        end
        endcase
    end

    // Output register
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_kind  <= emit_kind;
            r_out_value <= emit_value;
            r_out_last  <= i_cmd.emit_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_kind    = r_out_kind;
    assign o_out_value   = r_out_value;
    assign o_last_of_run = r_out_last;

    always_comb begin
        o_sts.kind         = r_kind;
        o_sts.is_esc       = (r_byte == r_escape_char);
        o_sts.gap_gt_guard = (r_gap > {8'd0, r_guard_ticks});
        o_sts.gap_lt_guard = (r_gap < {8'd0, r_guard_ticks});
        o_sts.is_a         = (upper == CH_A);
        o_sts.is_t         = (upper == CH_T);
        o_sts.is_slash     = (upper == CH_SLASH);
        o_sts.is_bs        = (upper == r_bs_char);
        o_sts.is_eol       = (upper == r_eol_char);
        o_sts.echo_en      = r_echo_enable;
        o_sts.line_empty   = (r_line_len == '0);
        o_sts.line_full    = (r_line_len == LEN_W'(LINE_DEPTH));
        o_sts.line_done    = (r_rd_idx == r_line_len);
        o_sts.out_free     = out_free;
    end

endmodule

`default_nettype wire

// ----- rtl/atf_ctrl.sv -----
// Controller of the AT front end: mode and escape state, decision on each
// item and the result sequencer. Depends on atf_pkg.
`default_nettype none

module atf_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire atf_pkg::t_dp_sts i_sts,
    output atf_pkg::t_dp_cmd      o_cmd
);
    import atf_pkg::*;

    t_state     r_state, n_state;
    logic       r_data_mode, n_data_mode;
    logic       r_esc_held, n_esc_held;
    logic [1:0] r_esc_cnt, n_esc_cnt;
    t_phase     r_phase, n_phase;
    logic       r_just, n_just;
    logic [1:0] r_esc_left, n_esc_left;
    t_act       r_act, n_act;

    t_state     d_next;
    t_act       d_act;
    t_line_op   d_lop;
    logic [1:0] d_esc_n;

    function automatic t_state act_state(input t_act act, input logic empty);
        t_state s;
        unique case (act)
            ACT_REPEAT:  s = S_REPEAT;
            ACT_ECHO_T:  s = S_ECHO_T;
            ACT_ECHO_BS: s = S_ECHO_BS;
            ACT_LINE:    s = empty ? S_LEN : S_LINE_RD;
            default:     s = S_IDLE;
        endcase
        return s;
    endfunction

    // Decision on the item held in the datapath
    always_comb begin
        d_next      = S_IDLE;
        d_act       = ACT_NONE;
        d_lop       = LOP_NONE;
        d_esc_n     = r_esc_left;
        n_data_mode = r_data_mode;
        n_esc_held  = r_esc_held;
        n_esc_cnt   = r_esc_cnt;
        n_phase     = r_phase;
        n_just      = r_just;
        if (r_state == S_DECIDE) begin
            if (i_sts.kind) begin
                n_data_mode = 1'b1;
                n_esc_held  = 1'b0;
                n_esc_cnt   = '0;
                n_just      = 1'b0;
            end else if (r_data_mode) begin
                if (!r_esc_held) begin
                    if (i_sts.is_esc && i_sts.gap_gt_guard) begin
                        n_esc_held = 1'b1;
                        n_esc_cnt  = 2'd1;
                    end else begin
                        d_next = S_BYTE;
                    end
                end else if (!i_sts.is_esc) begin
                    // broken off: release held escapes, then the byte
                    d_esc_n    = r_esc_cnt;
                    d_next     = S_ESC;
                    n_esc_held = 1'b0;
                    n_esc_cnt  = '0;
                end else if (r_esc_cnt == ESC_RUN - 2'd1) begin
                    n_data_mode = 1'b0;
                    n_esc_held  = 1'b0;
                    n_esc_cnt   = '0;
                    n_phase     = PH_WAIT_A;
                    n_just      = 1'b1;
                    d_next      = S_ENTERED;
                end else begin
                    n_esc_cnt = r_esc_cnt + 2'd1;
                end
            end else if (r_just && i_sts.gap_lt_guard) begin
                // quick byte right after escape: back to data mode
                n_just      = 1'b0;
                d_esc_n     = ESC_RUN;
                d_next      = S_ESC;
                n_data_mode = 1'b1;
                n_esc_held  = 1'b0;
                n_esc_cnt   = '0;
            end else begin
                n_just = 1'b0;
                unique case (r_phase)
                    PH_WAIT_T: begin
                        if (i_sts.is_t) begin
                            d_lop   = LOP_CLEAR;
                            n_phase = PH_COLLECT;
                        end else begin
                            if (i_sts.is_slash) begin
                                d_act = ACT_REPEAT;
                            end
                            n_phase = PH_WAIT_A;
                        end
                    end
                    PH_COLLECT: begin
                        if (i_sts.is_bs) begin
                            if (i_sts.line_empty) begin
                                if (i_sts.echo_en) begin
                                    d_act = ACT_ECHO_T;
                                end
                            end else begin
                                d_lop = LOP_POP;
                                if (i_sts.echo_en) begin
                                    d_act = ACT_ECHO_BS;
                                end
                            end
                        end else if (i_sts.is_eol) begin
                            d_act   = ACT_LINE;
                            n_phase = PH_WAIT_A;
                        end else if (!i_sts.line_full) begin
                            d_lop = LOP_PUSH;
                        end
                    end
                    default: begin
                        n_phase = i_sts.is_a ? PH_WAIT_T : PH_WAIT_A;
                    end
                endcase
                d_next = i_sts.echo_en ? S_ECHO : act_state(d_act, i_sts.line_empty);
            end
        end
    end

    // Next state
    always_comb begin
        n_state    = r_state;
        n_act      = r_act;
        n_esc_left = r_esc_left;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state    = d_next;
                n_act      = d_act;
                n_esc_left = d_esc_n;
            end
            S_ESC: begin
                if (i_sts.out_free) begin
                    n_esc_left = r_esc_left - 2'd1;
                    if (r_esc_left == 2'd1) begin
                        n_state = S_BYTE;
                    end
                end
            end
            S_BYTE, S_ENTERED, S_ECHO_T, S_ECHO_SP, S_REPEAT, S_LEN: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_ECHO: begin
                if (i_sts.out_free) begin
                    n_state = act_state(r_act, i_sts.line_empty);
                end
            end
            S_ECHO_BS: begin
                if (i_sts.out_free) begin
                    n_state = S_ECHO_SP;
                end
            end
            S_LINE_RD: begin
                n_state = S_LINE;
            end
            S_LINE: begin
                if (i_sts.out_free && i_sts.line_done) begin
                    n_state = S_LEN;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd          = '0;
        o_cmd.emit_sel = SEL_RAW_LINE;
        o_cmd.line_op  = LOP_NONE;
        o_in_ready     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_DECIDE: begin
                o_cmd.line_op = d_lop;
            end
            S_ESC: begin
                o_cmd.emit     = i_sts.out_free;
                o_cmd.emit_sel = SEL_ESC_LINE;
            end
            S_BYTE: begin
                o_cmd.emit      = i_sts.out_free;
                o_cmd.emit_sel  = SEL_RAW_LINE;
                o_cmd.emit_last = 1'b1;
            end
            S_ENTERED: begin
                o_cmd.emit      = i_sts.out_free;
                o_cmd.emit_sel  = SEL_ENTERED;
                o_cmd.emit_last = 1'b1;
            end
            S_ECHO: begin
                o_cmd.emit      = i_sts.out_free;
                o_cmd.emit_sel  = SEL_ECHO_RAW;
                o_cmd.emit_last = (r_act == ACT_NONE);
            end
            S_ECHO_T: begin
                o_cmd.emit      = i_sts.out_free;
                o_cmd.emit_sel  = SEL_ECHO_T;
                o_cmd.emit_last = 1'b1;
            end
            S_ECHO_BS: begin
                o_cmd.emit     = i_sts.out_free;
                o_cmd.emit_sel = SEL_ECHO_BS;
            end
            S_ECHO_SP: begin
                o_cmd.emit      = i_sts.out_free;
                o_cmd.emit_sel  = SEL_ECHO_SP;
                o_cmd.emit_last = 1'b1;
            end
            S_REPEAT: begin
                o_cmd.emit      = i_sts.out_free;
                o_cmd.emit_sel  = SEL_REPEAT;
                o_cmd.emit_last = 1'b1;
            end
            S_LINE_RD: begin
                o_cmd.rd_start = 1'b1;
            end
            S_LINE: begin
                o_cmd.emit     = i_sts.out_free;
                o_cmd.emit_sel = SEL_STORE;
                o_cmd.rd_next  = i_sts.out_free && !i_sts.line_done;
            end
            S_LEN: begin
                o_cmd.emit      = i_sts.out_free;
                o_cmd.emit_sel  = SEL_LEN;
                o_cmd.emit_last = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_data_mode <= 1'b0;
            r_esc_held  <= 1'b0;
            r_esc_cnt   <= '0;
            r_phase     <= PH_WAIT_A;
            r_just      <= 1'b0;
            r_esc_left  <= '0;
            r_act       <= ACT_NONE;
        end else begin
            r_state     <= n_state;
            r_data_mode <= n_data_mode;
            r_esc_held  <= n_esc_held;
            r_esc_cnt   <= n_esc_cnt;
            r_phase     <= n_phase;
            r_just      <= n_just;
            r_esc_left  <= n_esc_left;
            r_act       <= n_act;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/at_escape_and_command_line_front_core.sv -----
// Top level of the AT escape and command line front end.
// Depends on atf_pkg, atf_if.sv, atf_ctrl and atf_datapath.
//
//   Channel  Dir  Payload                          Request moves
//   i_in     in   kind, host_byte, gap_ticks       one host byte or data-mode order
//   o_out    out  out_kind, out_value, last_of_run one result
//   i_cfg    in   index, data                      one register write (always ready)
//
// Sequence: an item is accepted, then decoded, then its results go out one per
// cycle while the output register has room; releasing a non-empty command line
// first reads the line store. The result sequencer in atf_ctrl sets this order.
// Reset: synchronous; no clearing pass, the line store holds no reset value
// and only entries below the line length are read.
// Stalls: results go through a one-entry output register; i_in.ready is low from
// acceptance until the item's last result (if any) sits in that register.
`default_nettype none

module at_escape_and_command_line_front_core #(
    parameter int LINE_DEPTH = 40
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    atf_item_if.sink   i_in,
    atf_result_if.source o_out,
    atf_cfg_if.sink    i_cfg
);
    import atf_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    in_ready;

    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;   // registers take a write every cycle

    // Mode, escape and phase tracking plus the result sequencer
    atf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Registers, line store and output stage
    atf_datapath #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_kind        (i_in.kind),
        .i_host_byte   (i_in.host_byte),
        .i_gap_ticks   (i_in.gap_ticks),
        .i_cfg_valid   (i_cfg.valid),
        .i_cfg_index   (i_cfg.index),
        .i_cfg_data    (i_cfg.data),
        .o_out_valid   (o_out.valid),
        .i_out_ready   (o_out.ready),
        .o_out_kind    (o_out.out_kind),
        .o_out_value   (o_out.out_value),
        .o_last_of_run (o_out.last_of_run)
    );

endmodule

`default_nettype wire

// ----- rtl/atf_checker.sv -----
// Port-level checks of the AT front end and their bind to the top level.
// Depends on atf_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module atf_checker #(
    parameter int LINE_DEPTH = 40
) (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic [2:0] i_out_kind,
    input wire logic [7:0] i_out_value,
    input wire logic       i_out_last
);
    import atf_pkg::*;

    `ATF_ASSERT_ALWAYS(a_out_idle_after_rst, i_clk,
        !i_rst_n |=> !i_out_valid, "result valid after reset")

    // a run in progress keeps the input closed
    `ATF_ASSERT(a_no_accept_mid_run, i_clk, i_rst_n,
        i_out_valid && !i_out_last |-> !i_in_ready, "input ready during a run")

    `ATF_ASSERT(a_len_in_range, i_clk, i_rst_n,
        i_out_valid && i_out_kind == KIND_LINE_END |-> i_out_value <= 8'(LINE_DEPTH),
        "line length beyond store depth")

    `ATF_ASSERT(a_repeat_alone, i_clk, i_rst_n,
        i_out_valid && i_out_kind == KIND_REPEAT |-> i_out_value == 8'd0 && i_out_last,
        "repeat result malformed")

endmodule

bind at_escape_and_command_line_front_core atf_checker #(
    .LINE_DEPTH (LINE_DEPTH)
) u_atf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_kind  (o_out.out_kind),
    .i_out_value (o_out.out_value),
    .i_out_last  (o_out.last_of_run)
);

`default_nettype wire
